FILE: src/uf_pkg.sv
// Shared types and constants for the union-find block.
`timescale 1ns / 1ps
package uf_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int NODE_W     = 10;
  localparam int RANK_W     = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  localparam logic [1:0] OP_MAKE    = 2'd0;
  localparam logic [1:0] OP_CONNECT = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  // One node entry: created flag, rank and parent link.
  typedef struct packed {
    logic              created;
    logic [RANK_W-1:0] rank;
    idx_t              parent;
  } entry_t;

  // Write request into the node memory.
  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } wr_req_t;

endpackage

FILE: src/uf_mem.sv
// Node memory: one write port and one read port with registered read data.
`timescale 1ns / 1ps
module uf_mem (
  input  logic            clk,
  input  uf_pkg::wr_req_t wr,
  input  uf_pkg::idx_t    rd_addr,
  output uf_pkg::entry_t  rd_data
);
  import uf_pkg::*;

  entry_t mem [NODE_COUNT];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/union_find_by_rank.sv
// Top level of the union-find (disjoint-set forest, union by rank) block.
//
//   channel   ports                                          handshake
//   input     in_operation, in_node_a, in_node_b             start high while busy low
//   result    out_same_set, out_root_of_a, out_status        out_valid one-cycle strobe
//
// After reset the block sweeps the node memory, one entry per cycle, to clear
// every created flag: busy stays high until the sweep is done.
// Make-set and unused operation codes need no walk: the result strobes in the
// cycle after the transaction. Connect and query walk both root chains through
// the memory at one read per cycle, first the chain of a, then that of b; a
// tied-rank link below RANK_MAX adds a write in S_BUMP to raise the new root's rank.
// Each chain stays within the log2 bound of the node count as long as no root
// with children is made again. Re-making such a root resets its rank, so chains
// can then grow past the log2 bound, up to the node count. An uncreated node
// ends the walk at the read of its own entry. The memory's single read port sets
// the pace of the walk. The receiver cannot stall: each result is shown for one cycle.
`timescale 1ns / 1ps
module union_find_by_rank (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_operation,
  input  logic [uf_pkg::NODE_W-1:0] in_node_a,
  input  logic [uf_pkg::NODE_W-1:0] in_node_b,
  output logic                     out_valid,
  output logic                     out_same_set,
  output logic [uf_pkg::NODE_W-1:0] out_root_of_a,
  output logic                     out_status
);
  import uf_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_WALK_A = 5'b00100,
    S_WALK_B = 5'b01000,
    S_BUMP   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  idx_t   clr_cnt_r, clr_cnt_nxt;
  logic   is_connect_r, is_connect_nxt;
  idx_t   node_b_r, node_b_nxt;
  idx_t   cur_r, cur_nxt;
  logic   first_r, first_nxt;
  idx_t   ra_r, ra_nxt;
  logic [RANK_W-1:0] rank_a_r, rank_a_nxt;
  idx_t   rb_r, rb_nxt;
  logic [RANK_W-1:0] rank_b_r, rank_b_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_same_r, out_same_nxt;
  logic [NODE_W-1:0] out_root_r, out_root_nxt;
  logic              out_status_r, out_status_nxt;

  wr_req_t wr;
  idx_t    rd_addr;
  entry_t  rd_data;

  logic a_in_range, b_in_range;

  uf_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // A node index beyond the forest size counts as never created.
  assign a_in_range = (32'(in_node_a) < NODE_COUNT);
  assign b_in_range = (32'(in_node_b) < NODE_COUNT);

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    is_connect_nxt = is_connect_r;
    node_b_nxt     = node_b_r;
    cur_nxt        = cur_r;
    first_nxt      = first_r;
    ra_nxt         = ra_r;
    rank_a_nxt     = rank_a_r;
    rb_nxt         = rb_r;
    rank_b_nxt     = rank_b_r;
    out_valid_nxt  = 1'b0;
    out_same_nxt   = 1'b0;
    out_root_nxt   = '0;
    out_status_nxt = 1'b0;
    wr             = '0;
    rd_addr        = cur_r;

    unique case (state_r)
      S_CLEAR: begin
        // Clear the created flag of every entry, one per cycle.
        wr.en   = 1'b1;
        wr.addr = clr_cnt_r;
        wr.data = '0;
        clr_cnt_nxt = clr_cnt_r + idx_t'(1);
        if (clr_cnt_r == idx_t'(NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        rd_addr = in_node_a[IDX_W-1:0];
        if (start) begin
          unique case (in_operation) inside
            OP_MAKE: begin
              out_valid_nxt = 1'b1;
              if (a_in_range) begin
                wr.en           = 1'b1;
                wr.addr         = in_node_a[IDX_W-1:0];
                wr.data.created = 1'b1;
                wr.data.rank    = '0;
                wr.data.parent  = in_node_a[IDX_W-1:0];
                out_root_nxt    = in_node_a;
              end else begin
                out_status_nxt = 1'b1;
              end
            end
            OP_CONNECT, OP_QUERY: begin
              if (a_in_range && b_in_range) begin
                // The read of node_a is issued this cycle.
                is_connect_nxt = (in_operation == OP_CONNECT);
                node_b_nxt     = in_node_b[IDX_W-1:0];
                cur_nxt        = in_node_a[IDX_W-1:0];
                first_nxt      = 1'b1;
                state_nxt      = S_WALK_A;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b1;
              end
            end
            default: begin
              // Unused code: nothing changes and the result is all zero.
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_WALK_A: begin
        // rd_data holds the entry of cur_r.
        if (first_r && !rd_data.created) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else if (rd_data.parent == cur_r) begin
          ra_nxt     = cur_r;
          rank_a_nxt = rd_data.rank;
          rd_addr    = node_b_r;
          cur_nxt    = node_b_r;
          first_nxt  = 1'b1;
          state_nxt  = S_WALK_B;
        end else begin
          rd_addr   = rd_data.parent;
          cur_nxt   = rd_data.parent;
          first_nxt = 1'b0;
        end
      end

      S_WALK_B: begin
        if (first_r && !rd_data.created) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else if (rd_data.parent == cur_r) begin
          rb_nxt     = cur_r;
          rank_b_nxt = rd_data.rank;
          state_nxt  = S_IDLE;
          out_valid_nxt = 1'b1;
          out_same_nxt  = (ra_r == cur_r);
          out_root_nxt  = NODE_W'(ra_r);
          if (is_connect_r && (ra_r != cur_r)) begin
            wr.en           = 1'b1;
            wr.data.created = 1'b1;
            if (rank_a_r > rd_data.rank) begin
              // Root of b goes under the root of a.
              wr.addr        = cur_r;
              wr.data.rank   = rd_data.rank;
              wr.data.parent = ra_r;
            end else begin
              // Root of a goes under the root of b.
              wr.addr        = ra_r;
              wr.data.rank   = rank_a_r;
              wr.data.parent = cur_r;
              out_root_nxt   = NODE_W'(cur_r);
              if ((rank_a_r == rd_data.rank) && (rd_data.rank != RANK_MAX)) begin
                // Tie: the new root's rank rises, in a second write.
                out_valid_nxt = 1'b0;
                state_nxt     = S_BUMP;
              end
            end
          end
        end else begin
          rd_addr   = rd_data.parent;
          cur_nxt   = rd_data.parent;
          first_nxt = 1'b0;
        end
      end

      S_BUMP: begin
        wr.en           = 1'b1;
        wr.addr         = rb_r;
        wr.data.created = 1'b1;
        wr.data.rank    = rank_b_r + RANK_W'(1);
        wr.data.parent  = rb_r;
        out_valid_nxt   = 1'b1;
        out_root_nxt    = NODE_W'(rb_r);
        state_nxt       = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_connect_r <= is_connect_nxt;
    node_b_r     <= node_b_nxt;
    cur_r        <= cur_nxt;
    first_r      <= first_nxt;
    ra_r         <= ra_nxt;
    rank_a_r     <= rank_a_nxt;
    rb_r         <= rb_nxt;
    rank_b_r     <= rank_b_nxt;
    out_same_r   <= out_same_nxt;
    out_root_r   <= out_root_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_same_set  = out_same_r;
  assign out_root_of_a = out_root_r;
  assign out_status    = out_status_r;

endmodule
